// ===== sv/kci_pkg.sv =====
// ----------------------------------------------------------------------------
// kci_pkg
// Shared types, constants and arithmetic helpers of the keyframe interpolator.
// ----------------------------------------------------------------------------
package kci_pkg;

	localparam int KEYS       = 64;
	localparam int IDX_W      = $clog2(KEYS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int PW         = 58;
	localparam int AW         = 37;
	localparam int BW         = 21;
	localparam int HW         = 20;
	localparam int DVD_W      = 56;
	localparam int DIV_STEPS  = DVD_W / 2;
	localparam int DCNT_W     = $clog2(DIV_STEPS + 1);

	localparam logic [2:0] METH_CLAMP_LO = 3'd0;
	localparam logic [2:0] METH_CLAMP_HI = 3'd1;
	localparam logic [2:0] METH_HOLD     = 3'd2;
	localparam logic [2:0] METH_LINEAR   = 3'd3;
	localparam logic [2:0] METH_CUBIC    = 3'd4;

	localparam logic [0:0] REG_KEY_COUNT = 1'b0;
	localparam logic [0:0] REG_DIVISOR   = 1'b1;

	localparam int MODE_HOLD   = 0;
	localparam int MODE_LINEAR = 1;

	typedef struct packed {
		logic        [15:0] t;
		logic signed [31:0] v;
		logic signed [31:0] s;
		logic signed [31:0] e;
		logic        [1:0]  mode;
	} row_t;

	typedef enum logic [1:0] {RD_ZERO, RD_LAST, RD_NEXT} rd_sel_t;

	typedef enum logic [2:0] {
		M_UU, M_U2U, M_H00, M_H01, M_H10, M_H11, M_BD, M_LIN
	} mul_sel_t;

	typedef enum logic [2:0] {
		R_NONE, R_LOW, R_HIGH, R_HOLD, R_LIN, R_CUB
	} res_sel_t;

	typedef struct packed {
		logic     wr_en;
		logic     q_ld;
		rd_sel_t  rd_sel;
		logic     prev_ld;
		logic     cur_ld;
		logic     i_clr;
		logic     i_inc;
		logic     div_ld_u;
		logic     div_ld_b;
		mul_sel_t mul_sel;
		logic     u_ld;
		logic     u2_ld;
		logic     u3_ld;
		logic     h_ld;
		logic     acc_ld;
		logic     a_ld;
		logic     b_ld;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic lo_clamp;
		logic hi_clamp;
		logic cont;
		logic div_busy;
		logic hold;
		logic lin;
	} stat_t;

	function automatic logic signed [PW-1:0] rnd16(input logic signed [PW-1:0] x);
		logic signed [PW-1:0] mag;
		logic signed [PW-1:0] r;
		mag = x[PW-1] ? -x : x;
		r   = (mag + PW'(32768)) >>> 16;
		return x[PW-1] ? -r : r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] x);
		if (x > PW'(64'sh7FFFFFFF))
			return 32'sh7FFFFFFF;
		else if (x < -PW'(64'sh80000000))
			return 32'sh80000000;
		else
			return x[31:0];
	endfunction

endpackage

// ===== sv/kci_ctrl.sv =====
// ----------------------------------------------------------------------------
// kci_ctrl
// Sequencer: clamp checks, key search, divides and multiply chain.
// ----------------------------------------------------------------------------
module kci_ctrl import kci_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  opcode,
	input  stat_t st,
	output cmd_t  cmd,
	output logic  busy,
	output logic  done
);

	typedef enum logic [20:0] {
		S_IDLE  = 21'h000001,
		S_CHK0  = 21'h000002,
		S_CHKN  = 21'h000004,
		S_SRCH  = 21'h000008,
		S_UDIV  = 21'h000010,
		S_LIN1  = 21'h000020,
		S_LIN2  = 21'h000040,
		S_CUB1  = 21'h000080,
		S_CUB2  = 21'h000100,
		S_CUB3  = 21'h000200,
		S_CUB4  = 21'h000400,
		S_CUB5  = 21'h000800,
		S_CUB6  = 21'h001000,
		S_CUB7  = 21'h002000,
		S_CUB8  = 21'h004000,
		S_CUB9  = 21'h008000,
		S_CUB10 = 21'h010000,
		S_CUB11 = 21'h020000,
		S_CUB12 = 21'h040000,
		S_BDIV  = 21'h080000,
		S_FIN   = 21'h100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_FIN);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.rd_sel  = RD_ZERO;
		cmd.mul_sel = M_UU;
		cmd.res_sel = R_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.wr_en = !opcode;
					cmd.q_ld  = opcode;
					if (opcode)
						state_d = S_CHK0;
				end
			end
			S_CHK0: begin
				cmd.prev_ld = 1'b1;
				if (st.lo_clamp) begin
					cmd.res_sel = R_LOW;
					state_d = S_FIN;
				end else begin
					cmd.rd_sel = RD_LAST;
					state_d = S_CHKN;
				end
			end
			S_CHKN: begin
				if (st.hi_clamp) begin
					cmd.res_sel = R_HIGH;
					state_d = S_FIN;
				end else begin
					cmd.i_clr  = 1'b1;
					cmd.rd_sel = RD_NEXT;
					state_d = S_SRCH;
				end
			end
			S_SRCH: begin
				if (st.cont) begin
					cmd.prev_ld = 1'b1;
					cmd.i_inc   = 1'b1;
					cmd.rd_sel  = RD_NEXT;
				end else begin
					cmd.cur_ld   = 1'b1;
					cmd.div_ld_u = 1'b1;
					state_d = S_UDIV;
				end
			end
			S_UDIV: begin
				if (!st.div_busy) begin
					cmd.u_ld = 1'b1;
					if (st.hold) begin
						cmd.res_sel = R_HOLD;
						state_d = S_FIN;
					end else if (st.lin)
						state_d = S_LIN1;
					else
						state_d = S_CUB1;
				end
			end
			S_LIN1: begin
				cmd.mul_sel = M_LIN;
				state_d = S_LIN2;
			end
			S_LIN2: begin
				cmd.res_sel = R_LIN;
				state_d = S_FIN;
			end
			S_CUB1: begin
				cmd.mul_sel = M_UU;
				state_d = S_CUB2;
			end
			S_CUB2: begin
				cmd.u2_ld = 1'b1;
				state_d = S_CUB3;
			end
			S_CUB3: begin
				cmd.mul_sel = M_U2U;
				state_d = S_CUB4;
			end
			S_CUB4: begin
				cmd.u3_ld = 1'b1;
				state_d = S_CUB5;
			end
			S_CUB5: begin
				cmd.h_ld = 1'b1;
				state_d = S_CUB6;
			end
			S_CUB6: begin
				cmd.mul_sel = M_H00;
				state_d = S_CUB7;
			end
			S_CUB7: begin
				cmd.acc_ld  = 1'b1;
				cmd.mul_sel = M_H01;
				state_d = S_CUB8;
			end
			S_CUB8: begin
				cmd.a_ld    = 1'b1;
				cmd.mul_sel = M_H10;
				state_d = S_CUB9;
			end
			S_CUB9: begin
				cmd.acc_ld  = 1'b1;
				cmd.mul_sel = M_H11;
				state_d = S_CUB10;
			end
			S_CUB10: begin
				cmd.b_ld = 1'b1;
				state_d = S_CUB11;
			end
			S_CUB11: begin
				cmd.mul_sel = M_BD;
				state_d = S_CUB12;
			end
			S_CUB12: begin
				cmd.div_ld_b = 1'b1;
				state_d = S_BDIV;
			end
			S_BDIV: begin
				if (!st.div_busy) begin
					cmd.res_sel = R_CUB;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/kci_dp.sv =====
// ----------------------------------------------------------------------------
// kci_dp
// Key table, config registers, shared multiplier, radix-4 restoring divider.
// ----------------------------------------------------------------------------
module kci_dp import kci_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output stat_t               st,
	input  logic                cfg_write,
	input  logic [0:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic [IDX_W-1:0]    key_index,
	input  logic [15:0]         key_time,
	input  logic signed [31:0]  key_value,
	input  logic signed [31:0]  key_start_slope,
	input  logic signed [31:0]  key_end_slope,
	input  logic [1:0]          key_mode,
	input  logic [23:0]         query_time,
	output logic signed [31:0]  curve_value,
	output logic [IDX_W-1:0]    segment,
	output logic [2:0]          method
);

	row_t                  mem_q [KEYS];
	row_t                  rd_q, prev_q, cur_q;
	logic [6:0]            kc_q;
	logic [7:0]            dv_q;
	logic [23:0]           q_q;
	logic [IDX_W-1:0]      i_q;
	logic [IDX_W-1:0]      rd_addr;
	logic [CNT_W-1:0]      n_eff;
	logic [IDX_W-1:0]      last;
	logic [7:0]            dv_eff;
	logic [15:0]           d_q, u_q, u2_q, u3_q;
	logic signed [HW-1:0]  h00_q, h01_q, h10_q, h11_q;
	logic signed [PW-1:0]  p_q, acc_q;
	logic signed [AW-1:0]  a_q, b_q;
	logic signed [AW-1:0]  mul_a;
	logic signed [BW-1:0]  mul_b;
	logic [DVD_W-1:0]      dvd_q;
	logic [15:0]           rem_q, dsr_q;
	logic [DCNT_W-1:0]     cnt_q;
	logic                  neg_q;
	logic [15:0]           rem_n;
	logic [DVD_W-1:0]      dvd_n;
	logic signed [24:0]    num_s;
	logic signed [16:0]    d_s;
	logic [23:0]           num;
	logic [15:0]           d_n;
	logic signed [PW-1:0]  p_mag;
	logic signed [PW-1:0]  p_rnd;
	logic signed [HW-1:0]  eu, eu2, eu3;
	logic signed [PW-1:0]  qterm;

	always_comb begin
		if (kc_q == '0)
			n_eff = CNT_W'(1);
		else if (kc_q > 7'(KEYS))
			n_eff = CNT_W'(KEYS);
		else
			n_eff = CNT_W'(kc_q);
		last   = IDX_W'(n_eff - CNT_W'(1));
		dv_eff = (dv_q == '0) ? 8'd1 : dv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kc_q <= 7'd1;
			dv_q <= 8'd30;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_KEY_COUNT: kc_q <= cfg_data[6:0];
				REG_DIVISOR:   dv_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		unique case (cmd.rd_sel)
			RD_ZERO: rd_addr = '0;
			RD_LAST: rd_addr = last;
			RD_NEXT: rd_addr = cmd.i_clr ? IDX_W'(1) : i_q + IDX_W'(cmd.i_inc ? 2 : 1);
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem_q[key_index] <= '{t: key_time, v: key_value, s: key_start_slope,
				e: key_end_slope, mode: key_mode};
		rd_q <= mem_q[rd_addr];
	end

	assign st.lo_clamp = ({q_q} <= {rd_q.t, 8'h00});
	assign st.hi_clamp = ({q_q} >= {rd_q.t, 8'h00});
	assign st.cont     = ((CNT_W'(i_q) + CNT_W'(2)) < n_eff) && ({rd_q.t, 8'h00} <= q_q);
	assign st.div_busy = (cnt_q != '0);
	assign st.hold     = prev_q.mode[MODE_HOLD];
	assign st.lin      = prev_q.mode[MODE_LINEAR];

	always_comb begin
		num_s = $signed({1'b0, q_q}) - $signed({1'b0, prev_q.t, 8'h00});
		num   = num_s[24] ? 24'd0 : num_s[23:0];
		d_s   = $signed({1'b0, rd_q.t}) - $signed({1'b0, prev_q.t});
		d_n   = (d_s < 17'sd1) ? 16'd1 : d_s[15:0];
		p_mag = p_q[PW-1] ? -p_q : p_q;
		p_rnd = rnd16(p_q);
		eu    = HW'(u_q);
		eu2   = HW'(u2_q);
		eu3   = HW'(u3_q);
		qterm = neg_q ? -$signed({2'b00, dvd_q}) : $signed({2'b00, dvd_q});
	end

	always_comb begin
		logic [16:0] r;
		rem_n = rem_q;
		dvd_n = dvd_q;
		for (int k = 0; k < 2; k++) begin
			r     = {rem_n, dvd_n[DVD_W-1]};
			dvd_n = {dvd_n[DVD_W-2:0], 1'b0};
			if (r >= {1'b0, dsr_q}) begin
				rem_n    = 16'(r - {1'b0, dsr_q});
				dvd_n[0] = 1'b1;
			end else
				rem_n = r[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (cmd.div_ld_u || cmd.div_ld_b)
			cnt_q <= DCNT_W'(DIV_STEPS);
		else if (cnt_q != '0)
			cnt_q <= cnt_q - DCNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_ld_u) begin
			dvd_q <= DVD_W'({num, 8'h00});
			dsr_q <= d_n;
			rem_q <= '0;
			neg_q <= 1'b0;
		end else if (cmd.div_ld_b) begin
			dvd_q <= DVD_W'(p_mag + PW'(dv_eff >> 1));
			dsr_q <= 16'(dv_eff);
			rem_q <= '0;
			neg_q <= p_q[PW-1];
		end else if (cnt_q != '0) begin
			dvd_q <= dvd_n;
			rem_q <= rem_n;
		end
	end

	always_comb begin
		unique case (cmd.mul_sel)
			M_UU: begin
				mul_a = AW'($signed({1'b0, u_q}));
				mul_b = BW'($signed({1'b0, u_q}));
			end
			M_U2U: begin
				mul_a = AW'($signed({1'b0, u2_q}));
				mul_b = BW'($signed({1'b0, u_q}));
			end
			M_H00: begin
				mul_a = AW'(prev_q.v);
				mul_b = BW'(h00_q);
			end
			M_H01: begin
				mul_a = AW'(cur_q.v);
				mul_b = BW'(h01_q);
			end
			M_H10: begin
				mul_a = AW'(prev_q.s);
				mul_b = BW'(h10_q);
			end
			M_H11: begin
				mul_a = AW'(cur_q.e);
				mul_b = BW'(h11_q);
			end
			M_BD: begin
				mul_a = b_q;
				mul_b = BW'($signed({1'b0, d_q}));
			end
			M_LIN: begin
				mul_a = AW'(AW'(cur_q.v) - AW'(prev_q.v));
				mul_b = BW'($signed({1'b0, u_q}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		p_q <= PW'(mul_a) * PW'(mul_b);
		if (cmd.q_ld)
			q_q <= query_time;
		if (cmd.prev_ld)
			prev_q <= rd_q;
		if (cmd.cur_ld) begin
			cur_q <= rd_q;
			d_q   <= d_n;
		end
		if (cmd.u_ld)
			u_q <= (dvd_q > DVD_W'(16'hFFFF)) ? 16'hFFFF : dvd_q[15:0];
		if (cmd.u2_ld)
			u2_q <= p_rnd[15:0];
		if (cmd.u3_ld)
			u3_q <= p_rnd[15:0];
		if (cmd.h_ld) begin
			h00_q <= HW'(2) * eu3 - HW'(3) * eu2 + HW'(65536);
			h01_q <= HW'(3) * eu2 - HW'(2) * eu3;
			h10_q <= eu3 - HW'(2) * eu2 + eu;
			h11_q <= eu3 - eu2;
		end
		if (cmd.acc_ld)
			acc_q <= p_q;
		if (cmd.a_ld)
			a_q <= AW'(rnd16(acc_q + p_q));
		if (cmd.b_ld)
			b_q <= AW'(rnd16(acc_q + p_q));
	end

	always_ff @(posedge clk) begin
		unique case (cmd.res_sel)
			R_NONE: ;
			R_LOW: begin
				curve_value <= rd_q.v;
				segment     <= '0;
				method      <= METH_CLAMP_LO;
			end
			R_HIGH: begin
				curve_value <= rd_q.v;
				segment     <= last;
				method      <= METH_CLAMP_HI;
			end
			R_HOLD: begin
				curve_value <= prev_q.v;
				segment     <= i_q;
				method      <= METH_HOLD;
			end
			R_LIN: begin
				curve_value <= sat32(PW'(prev_q.v) + rnd16(p_q));
				segment     <= i_q;
				method      <= METH_LINEAR;
			end
			R_CUB: begin
				curve_value <= sat32(PW'(a_q) + qterm);
				segment     <= i_q;
				method      <= METH_CUBIC;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			i_q <= '0;
		else if (cmd.i_clr)
			i_q <= '0;
		else if (cmd.i_inc)
			i_q <= i_q + IDX_W'(1);
	end

endmodule

// ===== sv/keyframe_curve_interpolator.sv =====
// ----------------------------------------------------------------------------
// keyframe_curve_interpolator
// Keyframe table with clamp, hold, linear and cubic Hermite evaluation.
// ----------------------------------------------------------------------------
// Write: no result, busy stays low. One evaluate at a time.
// Evaluate, clamped: the key-0 or last-key check ends it, no search or divide.
// Evaluate, inside: clamp checks, a search of one key per cycle, then the
//   weight divide (2 quotient bits per cycle), then hold, linear, or cubic
//   (multiply chain and second divide).
// Reset clears the sequencer and config (key_count 1, divisor 30); table is not.
module keyframe_curve_interpolator import kci_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                cfg_write,
	input  logic [0:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic                opcode,
	input  logic [IDX_W-1:0]    key_index,
	input  logic [15:0]         key_time,
	input  logic signed [31:0]  key_value,
	input  logic signed [31:0]  key_start_slope,
	input  logic signed [31:0]  key_end_slope,
	input  logic [1:0]          key_mode,
	input  logic [23:0]         query_time,
	output logic                done,
	output logic signed [31:0]  curve_value,
	output logic [IDX_W-1:0]    segment,
	output logic [2:0]          method
);

	cmd_t  cmd;
	stat_t st;

	kci_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	kci_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.key_index       (key_index),
		.key_time        (key_time),
		.key_value       (key_value),
		.key_start_slope (key_start_slope),
		.key_end_slope   (key_end_slope),
		.key_mode        (key_mode),
		.query_time      (query_time),
		.curve_value     (curve_value),
		.segment         (segment),
		.method          (method)
	);

endmodule
